@@ rtl/nvgm_pkg.sv @@
package nvgm_pkg;

  localparam int ADDR_W      = 8;
  localparam int OFFSET_W    = 7;
  localparam int FIELD_W     = 8;
  localparam int CMP_W       = FIELD_W + 1;
  localparam int MASK_LOW_W  = 64;
  localparam int MASK_HIGH_W = 23;
  localparam int MASK_BITS   = MASK_LOW_W + MASK_HIGH_W;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 64;

  localparam logic REG_MASK_LOW  = 1'b0;
  localparam logic REG_MASK_HIGH = 1'b1;

  typedef struct packed {
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] size;
    logic [FIELD_W-1:0] offset;
  } entry_t;

  typedef struct packed {
    logic busy;
  } scan_status_t;

endpackage

@@ rtl/nvgm_scan.sv @@
module nvgm_scan #(
  parameter int NUM_REGS   = 87,
  parameter int MAX_GROUPS = 8,
  parameter int GC_W       = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               rebuild,
  input  logic [nvgm_pkg::MASK_BITS-1:0]     mask,
  output nvgm_pkg::entry_t                   tbl [MAX_GROUPS],
  output logic [GC_W-1:0]                    group_count,
  output nvgm_pkg::scan_status_t             status
);
  import nvgm_pkg::*;

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int GI_W  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  logic [NUM_REGS-1:0] pbits;
  logic                active;
  logic [IDX_W-1:0]    r;
  logic [GC_W-1:0]     grp;
  logic                in_run;
  logic [FIELD_W-1:0]  cum;

  logic                persist;
  logic                last;
  logic                grp_ok;
  logic [GC_W-1:0]     grp_adv;
  logic [GC_W-1:0]     grp_final;
  logic [GC_W:0]       count_raw;
  logic [GC_W-1:0]     count_next;
  logic [FIELD_W-1:0]  start_val;

  for (genvar i = 0; i < NUM_REGS; i++) begin : g_bits
    if (i < MASK_BITS) begin : g_in
      assign pbits[i] = mask[i];
    end else begin : g_out
      assign pbits[i] = 1'b0;
    end
  end

  always_comb begin
    persist    = pbits[r];
    last       = (r == IDX_W'(NUM_REGS - 1));
    grp_ok     = (grp < GC_W'(MAX_GROUPS));
    grp_adv    = (in_run && grp_ok) ? grp + GC_W'(1) : grp;
    grp_final  = persist ? grp : grp_adv;
    count_raw  = persist ? {1'b0, grp_final} + (GC_W+1)'(1) : {1'b0, grp_final};
    count_next = (count_raw > (GC_W+1)'(MAX_GROUPS)) ? GC_W'(MAX_GROUPS)
                                                      : count_raw[GC_W-1:0];
    start_val  = FIELD_W'(r) + FIELD_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      group_count <= '0;
      r           <= '0;
      grp         <= '0;
      in_run      <= 1'b0;
      cum         <= '0;
      for (int g = 0; g < MAX_GROUPS; g++) begin
        tbl[g] <= '0;
      end
    end else if (rebuild) begin
      active <= 1'b1;
      r      <= '0;
      grp    <= '0;
      in_run <= 1'b0;
      cum    <= '0;
      for (int g = 0; g < MAX_GROUPS; g++) begin
        tbl[g] <= '0;
      end
    end else if (active) begin
      if (!persist) begin
        if (grp_adv < GC_W'(MAX_GROUPS)) begin
          tbl[grp_adv[GI_W-1:0]].start <= start_val;
          if (grp_adv != grp) begin
            tbl[grp_adv[GI_W-1:0]].offset <= cum;
          end
        end
        grp    <= grp_adv;
        in_run <= 1'b0;
      end else begin
        if (grp_ok) begin
          tbl[grp[GI_W-1:0]].size <= tbl[grp[GI_W-1:0]].size + FIELD_W'(1);
          cum                     <= cum + FIELD_W'(1);
        end
        in_run <= 1'b1;
      end
      if (last) begin
        active      <= 1'b0;
        group_count <= count_next;
      end else begin
        r <= r + IDX_W'(1);
      end
    end
  end

  assign status.busy = active;

endmodule

@@ rtl/nvgm_lookup.sv @@
module nvgm_lookup #(
  parameter int MAX_GROUPS = 8,
  parameter int GC_W       = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [nvgm_pkg::ADDR_W-1:0]    reg_addr,
  input  nvgm_pkg::entry_t               tbl [MAX_GROUPS],
  input  logic [GC_W-1:0]                group_count,
  output logic                           valid,
  output logic                           in_group,
  output logic [nvgm_pkg::OFFSET_W-1:0]  page_offset
);
  import nvgm_pkg::*;

  logic                v1;
  logic [ADDR_W-1:0]   a1;
  logic                v2;
  logic [MAX_GROUPS-1:0] hit2;
  logic [OFFSET_W-1:0] off2 [MAX_GROUPS];

  logic [MAX_GROUPS-1:0] hit_next;
  logic [OFFSET_W-1:0] off_next [MAX_GROUPS];
  logic                sel_hit;
  logic [OFFSET_W-1:0] sel_off;

  always_comb begin
    for (int g = 0; g < MAX_GROUPS; g++) begin
      logic [CMP_W-1:0] ae;
      logic [CMP_W-1:0] s;
      logic [CMP_W-1:0] e;
      logic [CMP_W-1:0] d;
      ae = CMP_W'(a1);
      s  = CMP_W'(tbl[g].start);
      e  = s + CMP_W'(tbl[g].size);
      d  = ae + CMP_W'(tbl[g].offset) - s;
      hit_next[g] = (GC_W'(g) < group_count) && (ae >= s) && (ae < e);
      off_next[g] = d[OFFSET_W-1:0];
    end
  end

  always_comb begin
    sel_hit = 1'b0;
    sel_off = '0;
    for (int g = MAX_GROUPS - 1; g >= 0; g--) begin
      if (hit2[g]) begin
        sel_hit = 1'b1;
        sel_off = off2[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else begin
      v1    <= accept;
      v2    <= v1;
      valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    a1          <= reg_addr;
    hit2        <= hit_next;
    off2        <= off_next;
    in_group    <= sel_hit;
    page_offset <= sel_off;
  end

endmodule

@@ rtl/nv_register_group_mapper_core.sv @@
// Channel   Handshake                  Payload
// lookup    start / busy               reg_addr
// result    valid (one-cycle strobe)   in_group, page_offset
// config    APB psel/penable/pwrite    paddr, pwdata, prdata
//
// One lookup per cycle while busy is low; the result strobes valid after
// the item is taken and has passed the input, compare and select stages.
// A mask write starts a table rebuild that walks one register per cycle,
// so busy stays high until the walk has reached the last register.
// Reset clears the masks and the table; every lookup then misses.
// The receiver cannot stall, so the pipeline never holds.
module nv_register_group_mapper_core #(
  parameter int NUM_REGS   = 87,
  parameter int MAX_GROUPS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [nvgm_pkg::ADDR_W-1:0]     reg_addr,
  output logic                            valid,
  output logic                            in_group,
  output logic [nvgm_pkg::OFFSET_W-1:0]   page_offset,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nvgm_pkg::PADDR_W-1:0]    paddr,
  input  logic [nvgm_pkg::PDATA_W-1:0]    pwdata,
  output logic [nvgm_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import nvgm_pkg::*;

  localparam int GC_W = $clog2(MAX_GROUPS + 1);

  logic [MASK_LOW_W-1:0]  mask_low;
  logic [MASK_HIGH_W-1:0] mask_high;
  logic                   cfg_wr;
  logic                   accept;
  entry_t                 tbl [MAX_GROUPS];
  logic [GC_W-1:0]        group_count;
  scan_status_t           status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign accept = start && !busy;
  assign busy   = status.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_low  <= '0;
      mask_high <= '0;
    end else if (cfg_wr) begin
      case (paddr[3])
        REG_MASK_LOW:  mask_low  <= pwdata;
        REG_MASK_HIGH: mask_high <= pwdata[MASK_HIGH_W-1:0];
        default:       mask_low  <= mask_low;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_MASK_LOW:  prdata = mask_low;
      REG_MASK_HIGH: prdata = PDATA_W'(mask_high);
      default:       prdata = '0;
    endcase
  end

  nvgm_scan #(
    .NUM_REGS   (NUM_REGS),
    .MAX_GROUPS (MAX_GROUPS),
    .GC_W       (GC_W)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .rebuild     (cfg_wr),
    .mask        ({mask_high, mask_low}),
    .tbl         (tbl),
    .group_count (group_count),
    .status      (status)
  );

  nvgm_lookup #(
    .MAX_GROUPS (MAX_GROUPS),
    .GC_W       (GC_W)
  ) u_lookup (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .reg_addr    (reg_addr),
    .tbl         (tbl),
    .group_count (group_count),
    .valid       (valid),
    .in_group    (in_group),
    .page_offset (page_offset)
  );

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (valid && !in_group) |-> (page_offset == '0))
    else $error("miss with nonzero offset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 valid)
    else $error("result strobe missing three cycles after accept");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    (valid && in_group) |-> ({1'b0, page_offset} < FIELD_W'(NUM_REGS)))
    else $error("offset beyond register count");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(cfg_wr))
    else $error("rebuild without a mask write");

endmodule
